### hw/rtl/vfc_pkg.sv
// ----------------------------------------------------------------------------
// vfc_pkg
// Shared types and codes for the voxel face culler.
// ----------------------------------------------------------------------------
package vfc_pkg;

  localparam int COLOR_W = 24;
  localparam int COORD_W = 5;
  localparam int SIZE_W  = 6;
  localparam int CFG_IDX_W = 3;

  // commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_COLOR = 3'd3;

  // face codes, also the neighbor visit order
  localparam logic [2:0] FACE_NEG_Y = 3'd0;
  localparam logic [2:0] FACE_POS_Y = 3'd1;
  localparam logic [2:0] FACE_NEG_Z = 3'd2;
  localparam logic [2:0] FACE_POS_Z = 3'd3;
  localparam logic [2:0] FACE_POS_X = 3'd4;
  localparam logic [2:0] FACE_NEG_X = 3'd5;
  localparam int NUM_FACES = 6;

  localparam logic [SIZE_W-1:0]  SIZE_RESET = 6'd32;
  localparam logic [COLOR_W-1:0] KEY_RESET  = 24'hff00ff;

  typedef struct packed {
    logic               command;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [COORD_W-1:0] pos_z;
    logic [COLOR_W-1:0] color;
  } in_item_t;

  typedef struct packed {
    logic               face_valid;
    logic [2:0]         face;
    logic [COORD_W-1:0] face_x;
    logic [COORD_W-1:0] face_y;
    logic [COORD_W-1:0] face_z;
    logic [COLOR_W-1:0] face_color;
    logic               last;
  } out_item_t;

endpackage

### hw/rtl/voxel_face_culler.sv
// ----------------------------------------------------------------------------
// voxel_face_culler
// Voxel color grid with hidden-face culling queries.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid/in_stall/in_data): write or query items. A write
//   stores one color and finishes in the transfer cycle. A query walks the
//   center voxel and its six neighbors through the single-port voxel RAM,
//   one read per cycle, then emits one result per visible face (one to
//   six), or one not-valid result, one per cycle while the receiver does
//   not stall. The block takes no new item until the final result of a
//   query is in the output register.
//   out channel (out_valid/out_stall/out_data): results sit in an output
//   register; the next item can be taken while the final result of a query
//   still waits there. last marks the final result of each query.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready, drops
//   unknown indexes. The user writes only while the block is idle (unenforced).
//   Reset (rst, synchronous) restores sizes 32 and key color 0xff00ff and
//   clears the handshake state. Voxel RAM contents are not cleared: every
//   voxel in use must be written before it is queried.
//   A stalled receiver holds the output register and the emit sequence.
// ----------------------------------------------------------------------------
module voxel_face_culler
  import vfc_pkg::*;
#(
  parameter int MAX_X = 32,
  parameter int MAX_Y = 32,
  parameter int MAX_Z = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]   cfg_data
);

  localparam int DEPTH  = MAX_X * MAX_Y * MAX_Z;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CW     = (ADDR_W > SIZE_W + 4) ? ADDR_W : SIZE_W + 4;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  localparam logic [2:0] LAST_STEP = 3'd7;

  // clamp a size register to its grid parameter
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s,
                                                   input int mx);
    logic [9:0] m;
    m = 10'(mx);
    if ({4'd0, s} > m) return m[SIZE_W-1:0];
    return s;
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input logic [SIZE_W-1:0] x,
                                                input logic [SIZE_W-1:0] y,
                                                input logic [SIZE_W-1:0] z);
    logic [CW-1:0] a;
    a = CW'(x) + CW'(MAX_X) * (CW'(y) + CW'(MAX_Y) * CW'(z));
    return a[ADDR_W-1:0];
  endfunction

  // configuration
  logic [SIZE_W-1:0]  size_x, size_y, size_z;
  logic [COLOR_W-1:0] key_color;
  logic [SIZE_W-1:0]  eff_x, eff_y, eff_z;

  // control
  logic [1:0]  state;
  logic [2:0]  cnt;
  logic [COORD_W-1:0] qx, qy, qz;

  // read return tracking
  logic        rd_live;
  logic [2:0]  rd_step;
  logic        rd_inside;
  logic [COLOR_W-1:0] rd_data;
  logic        rd_empty;

  // gathered query result
  logic [COLOR_W-1:0]   center_col;
  logic                 center_empty;
  logic [NUM_FACES-1:0] mask;

  // voxel store
  logic [COLOR_W-1:0] mem [DEPTH];
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_addr;

  // neighbor address generation
  logic [2:0]        step_face;
  logic [SIZE_W-1:0] sx, sy, sz;
  logic              s_neg;
  logic              s_inside;
  logic              w_inside;

  // emit
  logic                 in_xfer;
  logic                 out_free;
  logic [2:0]           pick;
  logic [NUM_FACES-1:0] pick_bit;
  logic                 no_face;

  assign cfg_ready = 1'b1;
  assign eff_x = clamp_size(size_x, MAX_X);
  assign eff_y = clamp_size(size_y, MAX_Y);
  assign eff_z = clamp_size(size_z, MAX_Z);

  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x    <= SIZE_RESET;
      size_y    <= SIZE_RESET;
      size_z    <= SIZE_RESET;
      key_color <= KEY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SIZE_X:    size_x    <= cfg_data[SIZE_W-1:0];
        REG_SIZE_Y:    size_y    <= cfg_data[SIZE_W-1:0];
        REG_SIZE_Z:    size_z    <= cfg_data[SIZE_W-1:0];
        REG_KEY_COLOR: key_color <= cfg_data;
        default: ;
      endcase
    end
  end

  // step 0 is the center, step f+1 visits face f
  assign step_face = cnt - 3'd1;

  always_comb begin
    sx    = {1'b0, qx};
    sy    = {1'b0, qy};
    sz    = {1'b0, qz};
    s_neg = 1'b0;
    case (step_face)
      FACE_NEG_Y: begin
        s_neg = (qy == '0);
        sy    = {1'b0, qy} - 6'd1;
      end
      FACE_POS_Y: sy = {1'b0, qy} + 6'd1;
      FACE_NEG_Z: begin
        s_neg = (qz == '0);
        sz    = {1'b0, qz} - 6'd1;
      end
      FACE_POS_Z: sz = {1'b0, qz} + 6'd1;
      FACE_POS_X: sx = {1'b0, qx} + 6'd1;
      FACE_NEG_X: begin
        s_neg = (qx == '0);
        sx    = {1'b0, qx} - 6'd1;
      end
      default: ;
    endcase
  end

  assign s_inside = !s_neg && (sx < eff_x) && (sy < eff_y) && (sz < eff_z);
  assign w_inside = ({1'b0, in_data.pos_x} < eff_x) &&
                    ({1'b0, in_data.pos_y} < eff_y) &&
                    ({1'b0, in_data.pos_z} < eff_z);

  // writes happen only in idle, reads only while walking: one port suffices
  assign mem_we   = in_xfer && (in_data.command == CMD_WRITE) && w_inside;
  assign mem_addr = mem_we ? addr_of({1'b0, in_data.pos_x}, {1'b0, in_data.pos_y},
                                     {1'b0, in_data.pos_z})
                           : addr_of(sx, sy, sz);

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= in_data.color;
    rd_data <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) rd_live <= 1'b0;
    else     rd_live <= (state == S_READ) && (cnt != LAST_STEP);
    rd_step   <= cnt;
    rd_inside <= s_inside;
  end

  assign rd_empty = !rd_inside || (rd_data == key_color);

  always_ff @(posedge clk) begin
    if (rd_live) begin
      if (rd_step == 3'd0) begin
        center_col   <= rd_data;
        center_empty <= rd_empty;
      end
      for (int i = 0; i < NUM_FACES; i++) begin
        if (rd_step == 3'(i + 1)) mask[i] <= rd_empty;
      end
    end else if (state == S_EMIT && out_free) begin
      mask <= mask & ~pick_bit;
    end
  end

  // lowest pending face goes first
  always_comb begin
    pick     = '0;
    pick_bit = '0;
    for (int i = NUM_FACES - 1; i >= 0; i--) begin
      if (mask[i]) begin
        pick     = 3'(i);
        pick_bit = NUM_FACES'(1) << i;
      end
    end
  end

  assign no_face = center_empty || (mask == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      // in emit the output register is refilled whenever it frees up
      if (out_valid && !out_stall && state != S_EMIT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_xfer && in_data.command == CMD_QUERY) begin
            state <= S_READ;
            cnt   <= '0;
            qx    <= in_data.pos_x;
            qy    <= in_data.pos_y;
            qz    <= in_data.pos_z;
          end
        end
        S_READ: begin
          cnt <= cnt + 3'd1;
          if (cnt == LAST_STEP) state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid         <= 1'b1;
            out_data.face_x   <= qx;
            out_data.face_y   <= qy;
            out_data.face_z   <= qz;
            if (no_face) begin
              out_data.face_valid <= 1'b0;
              out_data.face       <= FACE_NEG_Y;
              out_data.face_color <= '0;
              out_data.last       <= 1'b1;
              state               <= S_IDLE;
            end else begin
              out_data.face_valid <= 1'b1;
              out_data.face       <= pick;
              out_data.face_color <= center_col;
              out_data.last       <= ((mask & ~pick_bit) == '0);
              if ((mask & ~pick_bit) == '0) state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a query starts its walk at the center voxel
  a_query_start: assert property (@(posedge clk) disable iff (rst)
    in_xfer && in_data.command == CMD_QUERY |=> state == S_READ && cnt == 3'd0)
    else $error("query did not start the neighbor walk");

  // the final walk cycle receives the last neighbor read
  a_walk_order: assert property (@(posedge clk) disable iff (rst)
    state == S_READ && cnt == LAST_STEP |-> rd_live && rd_step == 3'd6)
    else $error("neighbor read return out of order");

  // a not-valid result is always the only and final one
  a_invalid_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.face_valid || out_data.last)
    else $error("not-valid result without last");

  // the voxel RAM is never written during a query
  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> state == S_IDLE)
    else $error("voxel write while a query is in progress");

endmodule

### tb/tb_voxel_face_culler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_voxel_face_culler
// Self-checking bench for the voxel face culler. A scoreboard keeps its own
// copy of the voxel grid and size/key registers, predicts the face results of
// every query transfer and checks them in order against the out channel. It
// runs directed corner/bound cases, then random write/query traffic under
// several source/sink idle mixes and one long sink hold-off.
// ----------------------------------------------------------------------------
module tb_voxel_face_culler;
  import vfc_pkg::*;

  // Grid parameters of the instance; the scoreboard uses the same layout.
  localparam int GRID_X = 32;
  localparam int GRID_Y = 32;
  localparam int GRID_Z = 32;
  localparam int CELLS  = GRID_X * GRID_Y * GRID_Z;

  // Extra wait after the last owed result, before touching the config port
  // or ending the run.
  localparam int SETTLE_CYCLES  = 24;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;

  // Index past the last register; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COLOR_W-1:0]   cfg_data = '0;

  voxel_face_culler #(
    .MAX_X(GRID_X),
    .MAX_Y(GRID_Y),
    .MAX_Z(GRID_Z)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Scoreboard state: shadow grid, written flags, shadow registers, and the
  // queue of face results still owed by the block.
  // --------------------------------------------------------------------------
  logic [COLOR_W-1:0] voxel_color [CELLS];
  bit                 voxel_known [CELLS];
  logic [SIZE_W-1:0]  size_x_reg = SIZE_RESET;
  logic [SIZE_W-1:0]  size_y_reg = SIZE_RESET;
  logic [SIZE_W-1:0]  size_z_reg = SIZE_RESET;
  logic [COLOR_W-1:0] key_now    = KEY_RESET;
  out_item_t          pending_faces [$];
  out_item_t          face_want;

  int live_items     = 0;  // queries plus writes that land inside the grid
  int mismatch_count = 0;
  int src_idle_pct   = 0;
  int stall_pct      = 0;
  int hold_req       = 0;  // set by a test, picked up by the sink process
  int hold_left      = 0;
  int quiet_cycles   = 0;

  // Size registers above the grid parameter act as the parameter.
  function automatic int span(input logic [SIZE_W-1:0] s, input int limit);
    return (int'(s) > limit) ? limit : int'(s);
  endfunction

  function automatic bit in_grid(input int x, y, z);
    return x >= 0 && y >= 0 && z >= 0 &&
           x < span(size_x_reg, GRID_X) &&
           y < span(size_y_reg, GRID_Y) &&
           z < span(size_z_reg, GRID_Z);
  endfunction

  // Layout is fixed by the parameters, not by the size registers.
  function automatic int cell_of(input int x, y, z);
    return x + GRID_X * (y + GRID_Y * z);
  endfunction

  // Anything outside the grid reads as empty.
  function automatic logic [COLOR_W-1:0] color_at(input int x, y, z);
    if (!in_grid(x, y, z))
      return key_now;
    return voxel_color[cell_of(x, y, z)];
  endfunction

  function automatic void face_step(input int f, input int x, y, z,
                                    output int nx, ny, nz);
    nx = x;
    ny = y;
    nz = z;
    case (3'(f))
      FACE_NEG_Y: ny = y - 1;
      FACE_POS_Y: ny = y + 1;
      FACE_NEG_Z: nz = z - 1;
      FACE_POS_Z: nz = z + 1;
      FACE_POS_X: nx = x + 1;
      FACE_NEG_X: nx = x - 1;
      default: ;
    endcase
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [COLOR_W-1:0] data);
    case (idx)
      REG_SIZE_X:    size_x_reg = data[SIZE_W-1:0];
      REG_SIZE_Y:    size_y_reg = data[SIZE_W-1:0];
      REG_SIZE_Z:    size_z_reg = data[SIZE_W-1:0];
      REG_KEY_COLOR: key_now    = data;
      default: ;
    endcase
  endfunction

  // Update the shadow grid for a write, or queue the faces a query owes:
  // one per empty neighbor of a solid voxel in face order, else a single
  // not-valid result. The final one carries last.
  function automatic void cull_faces(input in_item_t item);
    int                 x, y, z, nx, ny, nz;
    logic [COLOR_W-1:0] body;
    out_item_t          face_out;
    out_item_t          faces [$];
    x = item.pos_x;
    y = item.pos_y;
    z = item.pos_z;
    if (item.command == CMD_WRITE) begin
      if (in_grid(x, y, z)) begin
        voxel_color[cell_of(x, y, z)] = item.color;
        voxel_known[cell_of(x, y, z)] = 1'b1;
        live_items++;
      end
    end else begin
      live_items++;
      body = color_at(x, y, z);
      if (body != key_now) begin
        for (int f = 0; f < NUM_FACES; f++) begin
          face_step(f, x, y, z, nx, ny, nz);
          if (color_at(nx, ny, nz) == key_now) begin
            face_out = '{face_valid: 1'b1, face: 3'(f), face_x: item.pos_x,
                         face_y: item.pos_y, face_z: item.pos_z,
                         face_color: body, last: 1'b0};
            faces.push_back(face_out);
          end
        end
      end
      if (faces.size() == 0) begin
        face_out = '{face_valid: 1'b0, face: FACE_NEG_Y, face_x: item.pos_x,
                     face_y: item.pos_y, face_z: item.pos_z,
                     face_color: '0, last: 1'b1};
        faces.push_back(face_out);
      end
      face_out      = faces.pop_back();
      face_out.last = 1'b1;
      faces.push_back(face_out);
      foreach (faces[i])
        pending_faces.push_back(faces[i]);
    end
  endfunction

  function automatic in_item_t make_item(input logic cmd, input int x, y, z,
                                         input logic [COLOR_W-1:0] color);
    in_item_t item;
    item.command = cmd;
    item.pos_x   = COORD_W'(x);
    item.pos_y   = COORD_W'(y);
    item.pos_z   = COORD_W'(z);
    item.color   = color;
    return item;
  endfunction

  // Roughly a third empty voxels so faces show up often.
  function automatic logic [COLOR_W-1:0] pick_color();
    int roll;
    roll = $urandom_range(99);
    if (roll < 35)
      return key_now;
    if (roll < 40)
      return '0;
    if (roll < 45)
      return '1;
    return COLOR_W'($urandom);
  endfunction

  function automatic int window_base(input int ext);
    return (ext > 4) ? $urandom_range(ext - 4) : 0;
  endfunction

  // Mostly a 4-wide window so writes get reused; sometimes anywhere.
  function automatic int pick_coord(input int base);
    if ($urandom_range(9) == 0)
      return $urandom_range(31);
    return base + $urandom_range(3);
  endfunction

  function automatic bit face_matches(input out_item_t want, got);
    return want.face_valid === got.face_valid &&
           want.face       === got.face &&
           want.face_x     === got.face_x &&
           want.face_y     === got.face_y &&
           want.face_z     === got.face_z &&
           want.face_color === got.face_color &&
           want.last       === got.last;
  endfunction

  task automatic log_mismatch(input string what, input out_item_t want,
                              input out_item_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $write("%0t %s: want v=%0d f=%0d (%0d,%0d,%0d) c=%h l=%0d,",
             $realtime, what,
             want.face_valid, want.face, want.face_x, want.face_y, want.face_z,
             want.face_color, want.last);
      $display(" got v=%0d f=%0d (%0d,%0d,%0d) c=%h l=%0d",
               got.face_valid, got.face, got.face_x, got.face_y, got.face_z,
               got.face_color, got.last);
    end
  endtask

  // --------------------------------------------------------------------------
  // Drivers. All inputs change by NBA right after a rising edge; handshake
  // signals are sampled right after the edge, i.e. the values the block saw.
  // --------------------------------------------------------------------------

  // Valid stays high between back-to-back transfers; it only drops inside
  // an idle gap or at drain.
  task automatic send_item(input in_item_t item);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    cull_faces(item);
  endtask

  task automatic paint(input int x, y, z, input logic [COLOR_W-1:0] color);
    send_item(make_item(CMD_WRITE, x, y, z, color));
  endtask

  // Make sure every in-grid cell the query reads has been written first.
  task automatic query_voxel(input int x, y, z);
    int nx, ny, nz;
    if (in_grid(x, y, z)) begin
      if (!voxel_known[cell_of(x, y, z)])
        paint(x, y, z, pick_color());
      for (int f = 0; f < NUM_FACES; f++) begin
        face_step(f, x, y, z, nx, ny, nz);
        if (in_grid(nx, ny, nz) && !voxel_known[cell_of(nx, ny, nz)])
          paint(nx, ny, nz, pick_color());
      end
    end
    send_item(make_item(CMD_QUERY, x, y, z, COLOR_W'($urandom)));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [COLOR_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    apply_reg(idx, data);
  endtask

  // Block must be idle. Size writes carry junk in the upper data bits.
  task automatic configure(input int sx, sy, sz, input logic [COLOR_W-1:0] key,
                           input bit stray = 1'b0);
    logic [COLOR_W-1:0] raw;
    raw = COLOR_W'($urandom);
    raw[SIZE_W-1:0] = SIZE_W'(sx);
    write_reg(REG_SIZE_X, raw);
    raw = COLOR_W'($urandom);
    raw[SIZE_W-1:0] = SIZE_W'(sy);
    write_reg(REG_SIZE_Y, raw);
    raw = COLOR_W'($urandom);
    raw[SIZE_W-1:0] = SIZE_W'(sz);
    write_reg(REG_SIZE_Z, raw);
    write_reg(REG_KEY_COLOR, key);
    // a write past the last register; any aliasing would change the key
    if (stray)
      write_reg(REG_UNUSED, ~key);
    cfg_valid <= 1'b0;
  endtask

  // Wait for every owed result, then let any trailing write settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_faces.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(input int sx, sy, sz, input logic [COLOR_W-1:0] key,
                              input int count);
    int lo_x, lo_y, lo_z, goal, x, y, z;
    configure(sx, sy, sz, key);
    lo_x = window_base(span(size_x_reg, GRID_X));
    lo_y = window_base(span(size_y_reg, GRID_Y));
    lo_z = window_base(span(size_z_reg, GRID_Z));
    goal = live_items + count;
    while (live_items < goal) begin
      x = pick_coord(lo_x);
      y = pick_coord(lo_y);
      z = pick_coord(lo_z);
      if ($urandom_range(99) < 40)
        paint(x, y, z, pick_color());
      else
        query_voxel(x, y, z);
    end
    drain();
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset config: far corner with all faces showing, a key-colored voxel at
  // the origin, and a solid voxel fully enclosed by solid neighbors.
  task automatic test_faces_at_corners();
    int nx, ny, nz;
    src_idle_pct = 0;
    stall_pct    = 0;
    paint(31, 31, 31, 24'hffffff);
    paint(31, 30, 31, key_now);
    paint(31, 31, 30, key_now);
    paint(30, 31, 31, key_now);
    query_voxel(31, 31, 31);
    paint(0, 0, 0, key_now);
    paint(1, 0, 0, 24'h000001);
    paint(0, 1, 0, 24'h800000);
    paint(0, 0, 1, 24'h7fffff);
    query_voxel(0, 0, 0);
    paint(5, 5, 5, 24'h123456);
    for (int f = 0; f < NUM_FACES; f++) begin
      face_step(f, 5, 5, 5, nx, ny, nz);
      paint(nx, ny, nz, 24'h654321);
    end
    query_voxel(5, 5, 5);
    drain();
  endtask

  // Odd sizes, an oversized z, key 0: out-of-grid writes are dropped, an
  // out-of-grid query is not valid, and grid edges count as empty.
  task automatic test_grid_bounds();
    configure(2, 1, 63, 24'h000000, 1'b1);
    paint(2, 0, 0, 24'h00aa55);
    paint(0, 1, 0, 24'h00aa55);
    query_voxel(31, 0, 0);
    paint(0, 0, 0, 24'habcdef);
    paint(1, 0, 0, 24'h000000);
    paint(0, 0, 1, 24'h000100);
    query_voxel(0, 0, 0);
    drain();
  endtask

  // Zero sizes: nothing is stored, every query is not valid.
  task automatic test_empty_grid();
    configure(0, 0, 0, COLOR_W'($urandom));
    paint(0, 0, 0, 24'h0f0f0f);
    query_voxel(0, 0, 0);
    query_voxel(31, 31, 31);
    drain();
  endtask

  task automatic test_traffic_steady();
    src_idle_pct = 0;
    stall_pct    = 0;
    random_phase(3, 2, 4, COLOR_W'($urandom), 28);
    random_phase(32, 32, 32, 24'h000000, 28);
  endtask

  task automatic test_traffic_sparse_source();
    src_idle_pct = 55;
    stall_pct    = 0;
    random_phase(63, 17, 8, COLOR_W'($urandom), 28);
    random_phase(1, 5, 2, 24'hffffff, 28);
  endtask

  task automatic test_traffic_stalled_sink();
    src_idle_pct = 0;
    stall_pct    = 55;
    random_phase(4, 4, 4, COLOR_W'($urandom), 28);
    random_phase(32, 1, 32, COLOR_W'($urandom), 28);
  endtask

  task automatic test_traffic_mixed();
    src_idle_pct = 28;
    stall_pct    = 28;
    random_phase(2, 2, 2, COLOR_W'($urandom), 28);
    random_phase(5, 31, 3, COLOR_W'($urandom), 28);
  endtask

  // Sink holds off for a long stretch while queries keep coming, so the
  // output register fills and the block stalls its input.
  task automatic test_output_backpressure();
    src_idle_pct = 0;
    stall_pct    = 0;
    configure(3, 3, 3, COLOR_W'($urandom));
    hold_req = HOLD_CYCLES;
    repeat (20)
      query_voxel($urandom_range(2), $urandom_range(2), $urandom_range(2));
    drain();
  endtask

  // --------------------------------------------------------------------------
  // Sink: random stall per cycle, or a counted hold-off when one is asked.
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Checker: each out transfer against the oldest owed result.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_faces.size() == 0) begin
        log_mismatch("unexpected result", '0, out_data);
      end else begin
        face_want = pending_faces.pop_front();
        if (!face_matches(face_want, out_data))
          log_mismatch("wrong result", face_want, out_data);
      end
    end
  end

  // Watchdog: too long without any transfer on any channel ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("voxel_face_culler: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Main sequence.
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_faces_at_corners();
    test_grid_bounds();
    test_empty_grid();
    test_traffic_steady();
    test_output_backpressure();
    test_traffic_sparse_source();
    test_traffic_stalled_sink();
    test_traffic_mixed();
    if (pending_faces.size() != 0)
      mismatch_count += pending_faces.size();
    if (mismatch_count == 0)
      $display("voxel_face_culler: match");
    else
      $display("voxel_face_culler: mismatch");
    $finish;
  end

endmodule

### sim.f
hw/rtl/vfc_pkg.sv
hw/rtl/voxel_face_culler.sv
tb/tb_voxel_face_culler.sv
